// File: rtl/core/sadm_pkg.sv
// Shared types and constants for the stereo align / fractional delay mixer.
// Used by the top level; stands alone with no dependencies.
package sadm_pkg;

    // Default sizes, handed down as top-level parameter defaults
    localparam int DEF_RING_DEPTH   = 2048;
    localparam int DEF_SAMPLE_WIDTH = 24;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CTRL_W      = 16;
    localparam int MODE_W      = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BALANCE = 2'd0,
        REG_OFFSET  = 2'd1,
        REG_PHASE   = 2'd2
    } cfg_reg_t;

    // Phase mode codes; codes above NO_DELAY_UNITY behave as it
    localparam logic [MODE_W-1:0] MODE_NORMAL         = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INVERT         = 3'd1;
    localparam logic [MODE_W-1:0] MODE_WIDE           = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WIDE_INVERT    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_NO_DELAY       = 3'd4;
    localparam logic [MODE_W-1:0] MODE_NO_DELAY_UNITY = 3'd5;

    // Gains are Q0.16, 0..65536, carried signed
    localparam int GAIN_W = 18;
    localparam logic signed [GAIN_W-1:0] UNITY_HALF = 18'sd32768;

    // Delay word: integer taps above a 16-bit fraction, at most 700 samples
    localparam int FRAC_W  = 16;
    localparam int NEAR_W  = 10;
    localparam int DELAY_W = NEAR_W + FRAC_W;
    localparam int RANGE_W = 10;
    localparam logic [RANGE_W-1:0] RANGE_NARROW = 10'd30;
    localparam logic [RANGE_W-1:0] RANGE_WIDE   = 10'd700;

    // Widths of the delay power chain
    localparam int MAG_W  = 16;                 // |offset|, up to 32768
    localparam int SQ_W   = 31;                 // a^2
    localparam int Q4_W   = 33;                 // a^4 >> 28
    localparam int Q5_W   = Q4_W + MAG_W;       // (a^4 >> 28) * a
    localparam int SCL_W  = Q5_W + RANGE_W;     // times range
    localparam int Q5_SHR = 31;

endpackage

// File: rtl/core/sadm_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module sadm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/stereo_align_fractional_delay_mix.sv
// Stereo-to-mono aligner: balance, polarity, fractional delay of one channel, saturated mix.
// Depends on sadm_pkg and on the sadm_ram delay ring.
//
//   channel   | direction | handshake          | payload
//   ----------+-----------+--------------------+--------------------------------
//   input     | in        | in_valid/in_ready  | left_sample, right_sample
//   output    | out       | out_valid/out_ready| mono_sample
//   config    | in        | cfg_we             | cfg_index, cfg_data
//
// An item steps through gain, near-tap read and ring write, far-tap read and
// interpolation, then mix; the single ring read port sets this. A new request is taken in
// the mix cycle when the output register is free, else once it drains.
// After reset the ring is zeroed one entry a cycle; no request is taken meanwhile.
// Every configuration write starts a recomputation of the delay, during which no
// request is taken. A stalled output holds the block in mix.
module stereo_align_fractional_delay_mix
    import sadm_pkg::*;
#(
    parameter int RING_DEPTH   = DEF_RING_DEPTH,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [CFG_INDEX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]          cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] left_sample,
    input  logic signed [SAMPLE_WIDTH-1:0] right_sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] mono_sample
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int AW = $clog2(RING_DEPTH);
    localparam int PW = SW + 1 + GAIN_W;        // gained product
    localparam int IW = SW + GAIN_W + 1;        // interpolation accumulator
    localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(RING_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAIN,
        S_TAP0,
        S_INTERP,
        S_OUT
    } state_t;

    // ------------------------------------------------------------------
    // Saturation helpers
    // ------------------------------------------------------------------
    function automatic logic signed [SW-1:0] sat_prod(input logic signed [PW-1:0] v);
        logic same;
        same = (v[PW-1:SW-1] == {(PW-SW+1){v[PW-1]}});
        if (same)
            sat_prod = v[SW-1:0];
        else if (v[PW-1])
            sat_prod = {1'b1, {(SW-1){1'b0}}};
        else
            sat_prod = {1'b0, {(SW-1){1'b1}}};
    endfunction

    function automatic logic signed [SW-1:0] sat_sum(input logic signed [SW:0] v);
        if (v[SW] == v[SW-1])
            sat_sum = v[SW-1:0];
        else if (v[SW])
            sat_sum = {1'b1, {(SW-1){1'b0}}};
        else
            sat_sum = {1'b0, {(SW-1){1'b1}}};
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                    state_reg, state_next;
    logic [CTRL_W-1:0]         balance_reg, balance_next;
    logic [CTRL_W-1:0]         offset_reg, offset_next;
    logic [MODE_W-1:0]         phase_reg, phase_next;
    logic                      calc_busy_reg, calc_busy_next;
    logic [1:0]                calc_step_reg, calc_step_next;
    logic [Q5_W-1:0]           calc_acc_reg, calc_acc_next;
    logic [DELAY_W-1:0]        delay_reg, delay_next;
    logic                      clr_active_reg, clr_active_next;
    logic [AW-1:0]             clr_addr_reg, clr_addr_next;
    logic [AW-1:0]             base_reg, base_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [SW-1:0]      mono_reg, mono_next;

    logic signed [SW-1:0]      l_in_reg, r_in_reg;
    logic signed [SW-1:0]      lg_reg, rg_reg;
    logic signed [SW-1:0]      tap0_reg, interp_reg;
    logic signed [SW-1:0]      lg_next, rg_next, tap0_next, interp_next;

    // ------------------------------------------------------------------
    // Mode decode
    // ------------------------------------------------------------------
    logic                      mode_inv, mode_wide, mode_unity, mode_nodelay;
    logic                      dir_left, dir_right;

    always_comb
    begin
        mode_inv     = 1'b0;
        mode_wide    = 1'b0;
        mode_unity   = 1'b0;
        mode_nodelay = 1'b0;
        case (phase_reg)
            MODE_NORMAL:      ;
            MODE_INVERT:      mode_inv = 1'b1;
            MODE_WIDE:        mode_wide = 1'b1;
            MODE_WIDE_INVERT:
            begin
                mode_wide = 1'b1;
                mode_inv  = 1'b1;
            end
            MODE_NO_DELAY:    mode_nodelay = 1'b1;
            default:
            begin
                mode_nodelay = 1'b1;
                mode_unity   = 1'b1;
            end
        endcase
    end

    assign dir_left  = !mode_nodelay && !offset_reg[CTRL_W-1] && (offset_reg != '0);
    assign dir_right = !mode_nodelay && offset_reg[CTRL_W-1];

    // ------------------------------------------------------------------
    // Delay power chain: d = ((a^4 >> 28) * a * range) >> 31
    // ------------------------------------------------------------------
    logic signed [CTRL_W:0]    offset_ext, offset_abs;
    logic [MAG_W-1:0]          mag;
    logic [RANGE_W-1:0]        range_sel;
    logic [2*SQ_W-1:0]         sq_prod;
    logic [SCL_W-1:0]          scl_prod;

    assign offset_ext = {offset_reg[CTRL_W-1], offset_reg};
    assign offset_abs = offset_ext[CTRL_W] ? -offset_ext : offset_ext;
    assign mag        = offset_abs[MAG_W-1:0];
    assign range_sel  = mode_wide ? RANGE_WIDE : RANGE_NARROW;
    assign sq_prod    = calc_acc_reg[SQ_W-1:0] * calc_acc_reg[SQ_W-1:0];
    assign scl_prod   = calc_acc_reg * range_sel;

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic signed [SW:0]        l_ext, r_ext, l_pol;
    logic signed [GAIN_W-1:0]  bal_ext, gain_l, gain_r;
    logic signed [PW-1:0]      prod_l, prod_r;
    logic [NEAR_W-1:0]         near_taps;
    logic [FRAC_W-1:0]         frac;
    logic [AW:0]               addr0_raw, addr1_raw;
    logic [AW-1:0]             addr0, addr1;
    logic signed [GAIN_W-1:0]  w_near, w_far;
    logic signed [IW-1:0]      interp_acc;
    logic signed [SW-1:0]      l_final, r_final;
    logic signed [SW:0]        mix_sum;
    logic signed [SW-1:0]      ring_rdata;
    logic                      ring_we;
    logic [AW-1:0]             ring_waddr, ring_raddr;
    logic signed [SW-1:0]      ring_wdata;
    logic                      in_fire, out_free;

    assign l_ext   = {l_in_reg[SW-1], l_in_reg};
    assign r_ext   = {r_in_reg[SW-1], r_in_reg};
    assign l_pol   = mode_inv ? -l_ext : l_ext;
    assign bal_ext = {{(GAIN_W-CTRL_W){balance_reg[CTRL_W-1]}}, balance_reg};
    assign gain_l  = mode_unity ? UNITY_HALF : UNITY_HALF - bal_ext;
    assign gain_r  = mode_unity ? UNITY_HALF : UNITY_HALF + bal_ext;
    assign prod_l  = (PW'(l_pol) * PW'(gain_l)) >>> FRAC_W;
    assign prod_r  = (PW'(r_ext) * PW'(gain_r)) >>> FRAC_W;
    assign lg_next = sat_prod(prod_l);
    assign rg_next = sat_prod(prod_r);

    assign near_taps = delay_reg[DELAY_W-1:FRAC_W];
    assign frac      = delay_reg[FRAC_W-1:0];

    // near + 1 stays below the ring depth, so one subtract wraps
    always_comb
    begin
        addr0_raw = {1'b0, base_reg} + (AW+1)'(near_taps);
        addr1_raw = addr0_raw + (AW+1)'(1);
        addr0     = (addr0_raw >= DEPTH_EXT) ? AW'(addr0_raw - DEPTH_EXT) : addr0_raw[AW-1:0];
        addr1     = (addr1_raw >= DEPTH_EXT) ? AW'(addr1_raw - DEPTH_EXT) : addr1_raw[AW-1:0];
    end

    // Near tap of zero is the sample being written this item: forward it
    assign tap0_next = (near_taps == '0) ? (dir_left ? lg_reg : rg_reg) : ring_rdata;

    assign w_near      = GAIN_W'({1'b0, ~frac} + (FRAC_W+1)'(1));
    assign w_far       = GAIN_W'(frac);
    assign interp_acc  = IW'(tap0_reg) * IW'(w_near) + IW'(ring_rdata) * IW'(w_far);
    assign interp_next = interp_acc[SW+FRAC_W-1:FRAC_W];

    assign l_final = dir_left  ? interp_reg : lg_reg;
    assign r_final = dir_right ? interp_reg : rg_reg;
    assign mix_sum = {l_final[SW-1], l_final} + {r_final[SW-1], r_final};

    // Ring port muxing
    assign ring_we    = clr_active_reg || ((state_reg == S_TAP0) && (dir_left || dir_right));
    assign ring_waddr = clr_active_reg ? clr_addr_reg : base_reg;
    assign ring_wdata = clr_active_reg ? '0 : (dir_left ? lg_reg : rg_reg);
    assign ring_raddr = (state_reg == S_GAIN) ? addr0 : addr1;

    sadm_ram #(
        .WIDTH (SW),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = !clr_active_reg && !calc_busy_reg
                       && ((state_reg == S_IDLE) || ((state_reg == S_OUT) && out_free));
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign mono_sample = mono_reg;

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        balance_next    = balance_reg;
        offset_next     = offset_reg;
        phase_next      = phase_reg;
        calc_busy_next  = calc_busy_reg;
        calc_step_next  = calc_step_reg;
        calc_acc_next   = calc_acc_reg;
        delay_next      = delay_reg;
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        base_next       = base_reg;
        out_valid_next  = out_valid_reg;
        mono_next       = mono_reg;

        // Zero the ring after reset
        if (clr_active_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
                clr_active_next = 1'b0;
            else
                clr_addr_next = clr_addr_reg + AW'(1);
        end

        // Configuration writes; any write restarts the delay computation
        if (cfg_we)
        begin
            case (cfg_index)
                REG_BALANCE: balance_next = cfg_data[CTRL_W-1:0];
                REG_OFFSET:  offset_next  = cfg_data[CTRL_W-1:0];
                REG_PHASE:   phase_next   = cfg_data[MODE_W-1:0];
                default:     ;
            endcase
            calc_busy_next = 1'b1;
            calc_step_next = 2'd0;
        end
        else if (calc_busy_reg)
        begin
            calc_step_next = calc_step_reg + 2'd1;
            case (calc_step_reg)
                2'd0: calc_acc_next = Q5_W'(mag) * Q5_W'(mag);
                2'd1: calc_acc_next = Q5_W'(sq_prod[Q4_W+27:28]);
                2'd2: calc_acc_next = calc_acc_reg[Q4_W-1:0] * Q5_W'(mag);
                default:
                begin
                    delay_next     = scl_prod[Q5_SHR+DELAY_W-1:Q5_SHR];
                    calc_busy_next = 1'b0;
                end
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_GAIN;
            end
            S_GAIN:   state_next = S_TAP0;
            S_TAP0:   state_next = S_INTERP;
            S_INTERP: state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    mono_next      = sat_sum(mix_sum);
                    base_next      = (base_reg == '0) ? LAST_ADDR : base_reg - AW'(1);
                    state_next     = in_fire ? S_GAIN : S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control state and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            balance_reg    <= '0;
            offset_reg     <= '0;
            phase_reg      <= MODE_NORMAL;
            calc_busy_reg  <= 1'b0;
            calc_step_reg  <= 2'd0;
            calc_acc_reg   <= '0;
            delay_reg      <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            base_reg       <= LAST_ADDR;
            out_valid_reg  <= 1'b0;
            mono_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            balance_reg    <= balance_next;
            offset_reg     <= offset_next;
            phase_reg      <= phase_next;
            calc_busy_reg  <= calc_busy_next;
            calc_step_reg  <= calc_step_next;
            calc_acc_reg   <= calc_acc_next;
            delay_reg      <= delay_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            base_reg       <= base_next;
            out_valid_reg  <= out_valid_next;
            mono_reg       <= mono_next;
        end
    end

    // Sample payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            l_in_reg <= left_sample;
            r_in_reg <= right_sample;
        end
        if (state_reg == S_GAIN)
        begin
            lg_reg <= lg_next;
            rg_reg <= rg_next;
        end
        if (state_reg == S_TAP0)
            tap0_reg <= tap0_next;
        if (state_reg == S_INTERP)
            interp_reg <= interp_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_request_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !in_ready
    ) else $error("request taken while the ring is being cleared");

    a_ring_write_slot: assert property (
        @(posedge clk) disable iff (!rst_n)
        ring_we |-> (clr_active_reg || (state_reg == S_TAP0))
    ) else $error("ring written outside the clear pass or the write slot");

    a_request_starts_item: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_GAIN)
    ) else $error("accepted request did not start an item");

    a_cfg_restarts_delay: assert property (
        @(posedge clk) disable iff (!rst_n)
        cfg_we |=> (calc_busy_reg && !in_ready)
    ) else $error("configuration write did not hold off requests for the delay update");

endmodule
